// ----- hdl/qdac_pkg.sv -----
// Shared types and constants of the quad DAC I2C frame builder.
package qdac_pkg;

  localparam int unsigned CHANNELS_DEF = 4;

  localparam logic [11:0] CODE_MAX        = 12'hFFF;
  localparam logic [12:0] MA_LOW_Q8       = 13'd1024;
  localparam logic [12:0] MA_HIGH_Q8      = 13'd5120;
  localparam logic [24:0] ROUND_HALF      = 25'd2048;
  localparam logic [7:0]  MULTI_WRITE_CMD = 8'h40;
  localparam logic [6:0]  BUS_ADDR_RST    = 7'd96;
  localparam logic [2:0]  MULTI_LAST      = 3'd2;

  typedef enum logic [1:0] {
    MODE_RAW      = 2'd0,
    MODE_CONFIG   = 2'd1,
    MODE_MILLIAMP = 2'd2,
    MODE_READ     = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KIND_FAST  = 2'd0,
    KIND_MULTI = 2'd1,
    KIND_READ  = 2'd2,
    KIND_ERR   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_PREP = 2'd1,
    ST_EMIT = 2'd2
  } state_e;

  typedef struct packed {
    logic [1:0]  pd;
    logic [11:0] code;
  } chan_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic frame_last;
  } ctrl_sts_t;

endpackage

// ----- hdl/quad_dac_i2c_frame_builder.sv -----
// Top level of the quad DAC I2C frame builder.
//
// Requests enter on a valid/ready channel: mode, channel, code, reference,
// gain, power-down and loop current. Each request yields one or more result
// bytes on a valid/ready output channel, each tagged with the bus address
// register and marked last on the final one. A set-raw or set-milliamp
// request yields the fast-write frame of two bytes per channel, a valid
// set-config request the three-byte multi-write frame, and a read, a bad
// channel or an oversized config code a single result with no byte.
// The bus address register is written through cfg_we_i and cfg_wdata_i.
// A request accepted in the idle state passes through the preparation state,
// where the cache is updated, and then the emit state, where the byte counter
// sends one result per cycle while the receiver does not stall. The next
// request is taken as soon as the last result sits in the output register.
// When the receiver stalls, the output register holds its result and the
// byte counter waits. Reset clears the cache to code zero, normal power,
// sets the bus address to 96 and leaves the block idle and ready.
module quad_dac_i2c_frame_builder #(
  parameter int unsigned CHANNELS = qdac_pkg::CHANNELS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [1:0]  channel_i,
  input  logic [15:0] code_value_i,
  input  logic        vref_select_i,
  input  logic        gain_select_i,
  input  logic [1:0]  power_down_i,
  input  logic [12:0] milliamp_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  frame_byte_o,
  output logic        has_byte_o,
  output logic [6:0]  target_address_o,
  output logic        last_o,
  output logic        status_o,
  output logic [11:0] cached_value_o
);

  qdac_pkg::ctrl_cmd_t cmd;
  qdac_pkg::ctrl_sts_t sts;

  qdac_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  qdac_datapath #(
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .mode_i           (mode_i),
    .channel_i        (channel_i),
    .code_value_i     (code_value_i),
    .vref_select_i    (vref_select_i),
    .gain_select_i    (gain_select_i),
    .power_down_i     (power_down_i),
    .milliamp_i       (milliamp_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .frame_byte_o     (frame_byte_o),
    .has_byte_o       (has_byte_o),
    .target_address_o (target_address_o),
    .last_o           (last_o),
    .status_o         (status_o),
    .cached_value_o   (cached_value_o)
  );

  // An accepted request keeps the input side closed in the next cycle.
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input still ready right after a request was accepted");

  // Error results carry no byte and end the request.
  a_error_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> !has_byte_o && last_o)
    else $error("error result carries a byte or is not last");

  // Byte results report ok status and no cached code.
  a_byte_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && has_byte_o |-> !status_o && cached_value_o == 12'd0)
    else $error("byte result with status or cached code set");

  // A result without a byte is always the only result of its request.
  a_nobyte_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_byte_o |-> last_o)
    else $error("result without byte is not last");

endmodule

// ----- hdl/qdac_ctrl.sv -----
// Controller state machine of the quad DAC I2C frame builder.
module qdac_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  qdac_pkg::ctrl_sts_t sts_i,
  output qdac_pkg::ctrl_cmd_t cmd_o
);

  qdac_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= qdac_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      qdac_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = qdac_pkg::ST_PREP;
        end
      end
      qdac_pkg::ST_PREP: begin
        state_d = qdac_pkg::ST_EMIT;
      end
      qdac_pkg::ST_EMIT: begin
        if (sts_i.out_free && sts_i.frame_last) begin
          state_d = qdac_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = qdac_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      qdac_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      qdac_pkg::ST_PREP: begin
        cmd_o.prep = 1'b1;
      end
      qdac_pkg::ST_EMIT: begin
        cmd_o.emit = sts_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// ----- hdl/qdac_datapath.sv -----
// Datapath of the quad DAC I2C frame builder: request registers, channel cache, byte output.
module qdac_datapath #(
  parameter int unsigned CHANNELS = qdac_pkg::CHANNELS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  qdac_pkg::ctrl_cmd_t cmd_i,
  output qdac_pkg::ctrl_sts_t sts_o,
  input  logic                cfg_we_i,
  input  logic [6:0]          cfg_wdata_i,
  input  logic [1:0]          mode_i,
  input  logic [1:0]          channel_i,
  input  logic [15:0]         code_value_i,
  input  logic                vref_select_i,
  input  logic                gain_select_i,
  input  logic [1:0]          power_down_i,
  input  logic [12:0]         milliamp_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          frame_byte_o,
  output logic                has_byte_o,
  output logic [6:0]          target_address_o,
  output logic                last_o,
  output logic                status_o,
  output logic [11:0]         cached_value_o
);

  localparam int unsigned IDX_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [2:0]  FAST_LAST = 3'(2 * CHANNELS - 1);
  localparam logic [2:0]  CH_LIMIT  = 3'(CHANNELS);

  // Request registers, loaded when a request is accepted.
  logic [1:0]  mode_q;
  logic [1:0]  ch_q;
  logic [15:0] code_q;
  logic        vref_q;
  logic        gain_q;
  logic [1:0]  pd_q;
  logic [12:0] ma_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      ch_q   <= channel_i;
      code_q <= code_value_i;
      vref_q <= vref_select_i;
      gain_q <= gain_select_i;
      pd_q   <= power_down_i;
      ma_q   <= milliamp_i;
    end
  end

  logic [6:0] bus_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_addr_q <= qdac_pkg::BUS_ADDR_RST;
    end else if (cfg_we_i) begin
      bus_addr_q <= cfg_wdata_i;
    end
  end

  // Code computation for set-raw and set-milliamp.
  logic [11:0] raw_code;
  logic [12:0] ma_clamped;
  logic [12:0] ma_span;
  logic [24:0] ma_scaled;
  logic [12:0] ma_quot;
  logic [11:0] ma_code;
  logic [11:0] new_code;
  logic        code_big;

  always_comb begin
    code_big = (code_q > {4'd0, qdac_pkg::CODE_MAX});
    raw_code = code_big ? qdac_pkg::CODE_MAX : code_q[11:0];
    if (ma_q < qdac_pkg::MA_LOW_Q8) begin
      ma_clamped = qdac_pkg::MA_LOW_Q8;
    end else if (ma_q > qdac_pkg::MA_HIGH_Q8) begin
      ma_clamped = qdac_pkg::MA_HIGH_Q8;
    end else begin
      ma_clamped = ma_q;
    end
    ma_span = ma_clamped - qdac_pkg::MA_LOW_Q8;
    // Multiply by 4095 as a shift by twelve less the value itself.
    ma_scaled = {ma_span, 12'd0} - {12'd0, ma_span} + qdac_pkg::ROUND_HALF;
    ma_quot   = ma_scaled[24:12];
    ma_code   = (ma_quot > {1'b0, qdac_pkg::CODE_MAX}) ? qdac_pkg::CODE_MAX
                                                         : ma_quot[11:0];
    new_code  = (mode_q == qdac_pkg::MODE_MILLIAMP) ? ma_code : raw_code;
  end

  qdac_pkg::kind_e kind_q, kind_d;

  always_comb begin
    if ({1'b0, ch_q} >= CH_LIMIT) begin
      kind_d = qdac_pkg::KIND_ERR;
    end else begin
      case (mode_q)
        qdac_pkg::MODE_READ:   kind_d = qdac_pkg::KIND_READ;
        qdac_pkg::MODE_CONFIG: kind_d = code_big ? qdac_pkg::KIND_ERR : qdac_pkg::KIND_MULTI;
        default:               kind_d = qdac_pkg::KIND_FAST;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      kind_q <= kind_d;
    end
  end

  // Channel cache, updated during the preparation cycle.
  qdac_pkg::chan_t cache_q [CHANNELS];
  logic [IDX_W-1:0] wr_idx;

  assign wr_idx = ch_q[IDX_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        cache_q[i] <= '0;
      end
    end else if (cmd_i.prep) begin
      if (kind_d == qdac_pkg::KIND_FAST) begin
        cache_q[wr_idx].code <= new_code;
      end else if (kind_d == qdac_pkg::KIND_MULTI) begin
        cache_q[wr_idx].code <= code_q[11:0];
        cache_q[wr_idx].pd   <= pd_q;
      end
    end
  end

  // Byte counter walks through the frame.
  logic [2:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load) begin
      cnt_q <= '0;
    end else if (cmd_i.emit) begin
      cnt_q <= sts_o.frame_last ? 3'd0 : cnt_q + 3'd1;
    end
  end

  logic [IDX_W-1:0] rd_idx;
  qdac_pkg::chan_t  rd_chan;

  assign rd_idx  = (kind_q == qdac_pkg::KIND_READ) ? ch_q[IDX_W-1:0] : cnt_q[IDX_W:1];
  assign rd_chan = cache_q[rd_idx];

  logic [7:0]  byte_d;
  logic        has_d;
  logic        last_d;
  logic        status_d;
  logic [11:0] cached_d;

  always_comb begin
    byte_d   = '0;
    has_d    = 1'b0;
    last_d   = 1'b1;
    status_d = 1'b0;
    cached_d = '0;
    case (kind_q)
      qdac_pkg::KIND_FAST: begin
        has_d  = 1'b1;
        last_d = (cnt_q == FAST_LAST);
        byte_d = cnt_q[0] ? rd_chan.code[7:0] : {2'b00, rd_chan.pd, rd_chan.code[11:8]};
      end
      qdac_pkg::KIND_MULTI: begin
        has_d  = 1'b1;
        last_d = (cnt_q == qdac_pkg::MULTI_LAST);
        case (cnt_q[1:0])
          2'd0:    byte_d = qdac_pkg::MULTI_WRITE_CMD | {5'd0, ch_q, 1'b0};
          2'd1:    byte_d = {vref_q, pd_q, gain_q, code_q[11:8]};
          default: byte_d = code_q[7:0];
        endcase
      end
      qdac_pkg::KIND_READ: begin
        cached_d = rd_chan.code;
      end
      default: begin
        status_d = 1'b1;
      end
    endcase
  end

  // Output register.
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      frame_byte_o     <= byte_d;
      has_byte_o       <= has_d;
      target_address_o <= bus_addr_q;
      last_o           <= last_d;
      status_o         <= status_d;
      cached_value_o   <= cached_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign sts_o.out_free    = !out_valid_q || out_ready_i;
  assign sts_o.frame_last  = last_d;

endmodule
